/* hw/rtl/matrix_rotate_90_defines.svh */
// Assertion macros shared by the matrix rotation RTL.
`ifndef MATRIX_ROTATE_90_DEFINES_SVH
`define MATRIX_ROTATE_90_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MR90_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define MR90_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* hw/rtl/mr90_pkg.sv */
// Shared types and constants for the matrix rotation block.
package mr90_pkg;

  localparam int unsigned MAX_SIDE_DEFAULT = 8;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned CFG_SIDE_W = 4;
  localparam int unsigned PROD_W     = 2 * CFG_SIDE_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE_CLOCKWISE = 2'd2;

  // One completed matrix waiting to be emitted
  typedef struct packed {
    logic                  bank;
    logic [CFG_SIDE_W-1:0] width;
    logic [CFG_SIDE_W-1:0] height;
    logic                  square;
    logic                  clockwise;
  } q_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } bk_state_e;

endpackage

/* hw/rtl/matrix_rotate_90.sv */
// Top level of the square matrix 90-degree rotator.
//
// Usage:
//   Configure matrix_width, matrix_height and rotate_clockwise through the
//   cfg channel (cfg_valid_i/cfg_ready_o, index, data) while the block is idle;
//   cfg_ready_o is always high. Feed elements in row-major order: a beat is
//   taken at each clock edge with start_i high and busy_o low.
//   The element that completes width*height loads hands the matrix to the
//   emitter. Results come out one per cycle on rotated_value_o, each valid
//   for exactly one cycle while result_valid_o is high; last_element_o marks
//   the final result and size_error_o flags a non-square matrix sent unrotated.
// Flow:
//   The queue fill, emitter state and store read register lie between the
//   beat that completes a matrix and its first result; its results then
//   follow back to back, and the emitter drops to idle before the next one,
//   which bounds the sustained rate. With two store banks the next matrix
//   loads at one element per cycle, while busy_o is low, as the previous one
//   is emitted; busy_o rises only when both banks hold completed matrices.
// Reset clears config to 8x8 clockwise, empties the queue and the load count.
// The receiver cannot stall: every result must be taken in its cycle.
`include "matrix_rotate_90_defines.svh"

module matrix_rotate_90 import mr90_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // element input
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic signed [VALUE_W-1:0] element_value_i,
  // results
  output logic                  result_valid_o,
  output logic signed [VALUE_W-1:0] rotated_value_o,
  output logic                  last_element_o,
  output logic                  size_error_o
);

  localparam int unsigned AddrW = $clog2(MAX_SIDE * MAX_SIDE) + 1;

  logic               accept;
  logic               wr_en, rd_en;
  logic [AddrW-1:0]   wr_addr, rd_addr;
  logic [VALUE_W-1:0] wr_data, rd_data;
  logic               push, pop;
  q_desc_t            push_desc, head_desc;
  q_status_t          q_status;

  // Configuration is always taken; writes land only while idle by contract.
  assign cfg_ready_o = 1'b1;

  // Hold off new beats only when both store banks wait to be emitted.
  assign busy_o = q_status.full;
  assign accept = start_i && !busy_o;

  mr90_front #(
    .MAX_SIDE(MAX_SIDE)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (accept),
    .element_value_i(element_value_i),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .push_o         (push),
    .desc_o         (push_desc)
  );

  mr90_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .pop_i   (pop),
    .head_o  (head_desc),
    .status_o(q_status)
  );

  mr90_store #(
    .MAX_SIDE(MAX_SIDE)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  mr90_back #(
    .MAX_SIDE(MAX_SIDE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_desc),
    .status_i      (q_status),
    .pop_o         (pop),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .result_valid_o(result_valid_o),
    .last_element_o(last_element_o),
    .size_error_o  (size_error_o)
  );

  assign rotated_value_o = rd_data;

  // Loading and emitting must never touch the same bank in one cycle.
  `MR90_ASSERT_NOW(a_bank_split, clk_i, rst_ni, wr_en && rd_en, wr_addr[AddrW-1] != rd_addr[AddrW-1])
  // Drop a matrix from the queue only when one is there.
  `MR90_ASSERT_NOW(a_pop_nonempty, clk_i, rst_ni, pop, !q_status.empty)
  // The last result of a matrix is never directly followed by another result.
  `MR90_ASSERT_NEXT(a_last_gap, clk_i, rst_ni, last_element_o, !result_valid_o)
  // A finished matrix is never pushed into a full queue.
  `MR90_ASSERT_NOW(a_push_room, clk_i, rst_ni, push, !q_status.full)

endmodule

/* hw/rtl/mr90_store.sv */
// Two-bank element store: one write port, one registered read port.
module mr90_store import mr90_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEFAULT,
  localparam int unsigned AddrW = $clog2(MAX_SIDE * MAX_SIDE) + 1
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AddrW-1:0]    wr_addr_i,
  input  logic [VALUE_W-1:0]  wr_data_i,
  input  logic                rd_en_i,
  input  logic [AddrW-1:0]    rd_addr_i,
  output logic [VALUE_W-1:0]  rd_data_o
);

  localparam int unsigned Depth = 2 ** AddrW;

  logic [VALUE_W-1:0] mem_q [Depth];
  logic [VALUE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/mr90_front.sv */
// Front end: configuration registers, element loading and matrix completion.
module mr90_front import mr90_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEFAULT,
  localparam int unsigned AddrW = $clog2(MAX_SIDE * MAX_SIDE) + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  accept_i,
  input  logic [VALUE_W-1:0]    element_value_i,
  output logic                  wr_en_o,
  output logic [AddrW-1:0]      wr_addr_o,
  output logic [VALUE_W-1:0]    wr_data_o,
  output logic                  push_o,
  output q_desc_t               desc_o
);

  localparam int unsigned BankDepth = MAX_SIDE * MAX_SIDE;
  localparam int unsigned IdxW      = $clog2(BankDepth);
  localparam int unsigned CntW      = $clog2(BankDepth + 1);
  localparam logic [CFG_SIDE_W-1:0] SideMax = CFG_SIDE_W'(MAX_SIDE);

  logic [CFG_SIDE_W-1:0] width_q, height_q;
  logic                  clockwise_q;
  logic [CntW-1:0]       count_q, count_d;
  logic                  bank_q, bank_d;
  logic [CFG_SIDE_W-1:0] width_side, height_side;
  logic [PROD_W-1:0]     total;
  logic [PROD_W-1:0]     count_inc;
  logic                  complete;

  function automatic logic [CFG_SIDE_W-1:0] clamp_side(input logic [CFG_SIDE_W-1:0] v);
    logic [CFG_SIDE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_SIDE_W'(1);
    end else if (v > SideMax) begin
      r = SideMax;
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= CFG_SIDE_W'(8);
      height_q    <= CFG_SIDE_W'(8);
      clockwise_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MATRIX_WIDTH:     width_q     <= cfg_data_i[CFG_SIDE_W-1:0];
        REG_MATRIX_HEIGHT:    height_q    <= cfg_data_i[CFG_SIDE_W-1:0];
        REG_ROTATE_CLOCKWISE: clockwise_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign width_side  = clamp_side(width_q);
  assign height_side = clamp_side(height_q);
  assign total       = width_side * height_side;
  assign count_inc   = PROD_W'(count_q) + PROD_W'(1);
  assign complete    = (count_inc >= total);

  always_comb begin
    count_d = count_q;
    bank_d  = bank_q;
    if (accept_i) begin
      if (complete) begin
        count_d = '0;
        bank_d  = ~bank_q;
      end else begin
        count_d = count_inc[CntW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bank_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      bank_q  <= bank_d;
    end
  end

  assign wr_en_o   = accept_i;
  assign wr_addr_o = {bank_q, count_q[IdxW-1:0]};
  assign wr_data_o = element_value_i;
  assign push_o    = accept_i && complete;

  always_comb begin
    desc_o.bank      = bank_q;
    desc_o.width     = width_side;
    desc_o.height    = height_side;
    desc_o.square    = (width_side == height_side);
    desc_o.clockwise = clockwise_q;
  end

endmodule

/* hw/rtl/mr90_queue.sv */
// Two-entry queue of completed matrices between front and back end.
module mr90_queue import mr90_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  q_desc_t   desc_i,
  input  logic      pop_i,
  output q_desc_t   head_o,
  output q_status_t status_o
);

  q_desc_t    entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q, fill_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  always_comb begin
    fill_d = fill_q;
    case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + 2'd1;
      2'b01:   fill_d = fill_q - 2'd1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      fill_q <= fill_d;
    end
  end

  assign head_o         = entry_q[rd_ptr_q];
  assign status_o.full  = (fill_q == 2'd2);
  assign status_o.empty = (fill_q == 2'd0);

endmodule

/* hw/rtl/mr90_back.sv */
// Back end: walks the rotated order, reads the store and times the result strobe.
module mr90_back import mr90_pkg::*; #(
  parameter int unsigned MAX_SIDE = MAX_SIDE_DEFAULT,
  localparam int unsigned AddrW = $clog2(MAX_SIDE * MAX_SIDE) + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_desc_t          head_i,
  input  q_status_t        status_i,
  output logic             pop_o,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  output logic             result_valid_o,
  output logic             last_element_o,
  output logic             size_error_o
);

  localparam int unsigned RcW   = $clog2(MAX_SIDE);
  localparam int unsigned IdxW  = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int unsigned LinW  = RcW + CFG_SIDE_W;

  bk_state_e             state_q, state_d;
  logic [RcW-1:0]        row_q, col_q;
  logic [CFG_SIDE_W-1:0] width_m1, height_m1;
  logic                  row_end, col_end, last_rc;
  logic [RcW-1:0]        src_row, src_col;
  logic [LinW-1:0]       src_prod, src_lin;
  logic                  valid_q, last_q, err_q;

  assign width_m1  = head_i.width - CFG_SIDE_W'(1);
  assign height_m1 = head_i.height - CFG_SIDE_W'(1);
  assign col_end   = (col_q == width_m1[RcW-1:0]);
  assign row_end   = (row_q == height_m1[RcW-1:0]);
  assign last_rc   = row_end && col_end;

  // Source position in the loaded matrix for output position (row, col)
  always_comb begin
    if (!head_i.square) begin
      src_row = row_q;
      src_col = col_q;
    end else if (head_i.clockwise) begin
      src_row = width_m1[RcW-1:0] - col_q;
      src_col = row_q;
    end else begin
      src_row = col_q;
      src_col = width_m1[RcW-1:0] - row_q;
    end
  end

  assign src_prod  = src_row * head_i.width;
  assign src_lin   = src_prod + LinW'(src_col);
  assign rd_addr_o = {head_i.bank, src_lin[IdxW-1:0]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!status_i.empty) state_d = BK_RUN;
      BK_RUN:  if (last_rc) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    rd_en_o = 1'b0;
    pop_o   = 1'b0;
    case (state_q)
      BK_RUN: begin
        rd_en_o = 1'b1;
        pop_o   = last_rc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= rd_en_o;
      if (state_q != BK_RUN) begin
        row_q <= '0;
        col_q <= '0;
      end else if (col_end) begin
        col_q <= '0;
        row_q <= row_q + RcW'(1);
      end else begin
        col_q <= col_q + RcW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_rc;
    err_q  <= ~head_i.square;
  end

  assign result_valid_o = valid_q;
  assign last_element_o = valid_q && last_q;
  assign size_error_o   = err_q;

endmodule
